// File: rtl/tao_pkg.sv
// ----------------------------------------------------------------------------
// tao_pkg
// Shared widths, angle constants and the context record carried down the pipe.
// ----------------------------------------------------------------------------
package tao_pkg;

   // result angle, Q3.13 radians
   localparam int ANGLE_W = 16;
   // arctan table entries never exceed pi/4 in Q3.13 (6434), so 13 bits
   localparam int ROM_W   = 13;
   // step between neighboring table entries stays below 2^11 for 8+ entries
   localparam int FRAC_W  = 11;
   // fraction bits of the angle format
   localparam int Q_FRAC  = 13;

   localparam logic signed [ANGLE_W-1:0] ANGLE_ZERO       = 16'sd0;
   localparam logic signed [ANGLE_W-1:0] ANGLE_PI         = 16'sd25736;
   localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI    = 16'sd12868;
   localparam logic signed [ANGLE_W-1:0] ANGLE_QUARTER_PI = 16'sd6434;

   // how the first-octant angle is turned into the final angle
   typedef struct packed {
      logic signed [ANGLE_W-1:0] base;    // angle the octant value is added to
      logic                      negate;  // subtract the octant value instead
      logic                      fixed;   // axis point: octant value is zero
      logic                      equal;   // |x| == |y|: octant value is pi/4
   } tao_ctx_type;

   localparam int CTX_W = $bits(tao_ctx_type);

endpackage

// File: rtl/tao_if.sv
// ----------------------------------------------------------------------------
// tao_if
// Valid/ready channels: coordinate requests in, angle results out.
// ----------------------------------------------------------------------------
interface tao_req_if #(
   parameter int INPUT_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [INPUT_WIDTH-1:0] x_coord;
   logic signed [INPUT_WIDTH-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface tao_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tao_pkg::ANGLE_W-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

// File: rtl/tao_fold.sv
// ----------------------------------------------------------------------------
// tao_fold
// Two stages: magnitudes and signs, then octant fold and numerator scaling.
// ----------------------------------------------------------------------------
module tao_fold #(
   parameter int INPUT_WIDTH   = 16,
   parameter int TABLE_ENTRIES = 32,
   localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [INPUT_WIDTH-1:0] in_x,
   input  logic signed [INPUT_WIDTH-1:0] in_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [INPUT_WIDTH-1:0]        out_rem,
   output logic [IDX_W-1:0]              out_low,
   output logic [INPUT_WIDTH-1:0]        out_large,
   output tao_pkg::tao_ctx_type          out_ctx
);
   import tao_pkg::*;

   localparam int QW = INPUT_WIDTH + IDX_W;

   // stage a: magnitudes
   logic                   va_ff;
   logic                   a_ready;
   logic [INPUT_WIDTH-1:0] ax_ff, ay_ff;
   logic                   xneg_ff, yneg_ff, xzero_ff, yzero_ff;

   // stage b: folded operands
   logic                   vb_ff;
   logic                   b_ready;
   logic [INPUT_WIDTH-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0]       low_ff, low_in;
   logic [INPUT_WIDTH-1:0] large_ff, large_in;
   tao_ctx_type            ctx_ff, ctx_in;

   logic                   x_big;
   logic [INPUT_WIDTH-1:0] small_val;
   logic [QW-1:0]          scaled;

   assign b_ready  = !vb_ff || out_ready;
   assign a_ready  = !va_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (a_ready) begin
         va_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         // the most negative input maps to 2^(W-1), exact as unsigned
         ax_ff    <= in_x[INPUT_WIDTH-1] ? INPUT_WIDTH'(-in_x) : INPUT_WIDTH'(in_x);
         ay_ff    <= in_y[INPUT_WIDTH-1] ? INPUT_WIDTH'(-in_y) : INPUT_WIDTH'(in_y);
         xneg_ff  <= in_x[INPUT_WIDTH-1];
         yneg_ff  <= in_y[INPUT_WIDTH-1];
         xzero_ff <= (in_x == '0);
         yzero_ff <= (in_y == '0);
      end
   end

   always_comb begin
      x_big         = ax_ff > ay_ff;
      ctx_in.base   = ANGLE_ZERO;
      ctx_in.negate = 1'b0;
      ctx_in.fixed  = 1'b0;
      ctx_in.equal  = 1'b0;
      if (yzero_ff) begin
         ctx_in.fixed = 1'b1;
         ctx_in.base  = (xzero_ff || xneg_ff) ? ANGLE_PI : ANGLE_ZERO;
      end else if (xzero_ff) begin
         ctx_in.fixed = 1'b1;
         ctx_in.base  = yneg_ff ? -ANGLE_HALF_PI : ANGLE_HALF_PI;
      end else begin
         ctx_in.equal = (ax_ff == ay_ff);
         if (!xneg_ff) begin
            if (!yneg_ff) begin
               ctx_in.base   = x_big ? ANGLE_ZERO : ANGLE_HALF_PI;
               ctx_in.negate = !x_big;
            end else begin
               ctx_in.base   = x_big ? ANGLE_ZERO : -ANGLE_HALF_PI;
               ctx_in.negate = x_big;
            end
         end else begin
            if (!yneg_ff) begin
               ctx_in.base   = x_big ? ANGLE_PI : ANGLE_HALF_PI;
               ctx_in.negate = x_big;
            end else begin
               ctx_in.base   = x_big ? -ANGLE_PI : -ANGLE_HALF_PI;
               ctx_in.negate = !x_big;
            end
         end
      end

      // axes and equal magnitudes bypass the table: divide 0 by 1
      if (ctx_in.fixed || ctx_in.equal) begin
         large_in  = INPUT_WIDTH'(1);
         small_val = '0;
      end else begin
         large_in  = x_big ? ax_ff : ay_ff;
         small_val = x_big ? ay_ff : ax_ff;
      end

      // small < large, so small*N / large < N and the top part is < large
      scaled = QW'(small_val) * QW'(TABLE_ENTRIES);
      rem_in = scaled[QW-1:IDX_W];
      low_in = scaled[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (b_ready) begin
         vb_ff <= va_ff;
      end
      if (b_ready && va_ff) begin
         rem_ff   <= rem_in;
         low_ff   <= low_in;
         large_ff <= large_in;
         ctx_ff   <= ctx_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;
   assign out_large = large_ff;
   assign out_ctx   = ctx_ff;

endmodule

// File: rtl/tao_div_cell.sv
// ----------------------------------------------------------------------------
// tao_div_cell
// One restoring-division step: shifts in a dividend bit, emits a quotient bit.
// ----------------------------------------------------------------------------
module tao_div_cell #(
   parameter int REM_W  = 16,
   parameter int LOW_W  = 5,
   parameter int SIDE_W = 19
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [REM_W-1:0]  in_rem,
   input  logic [REM_W-1:0]  in_divisor,
   input  logic [LOW_W-1:0]  in_low,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [REM_W-1:0]  out_rem,
   output logic [REM_W-1:0]  out_divisor,
   output logic [LOW_W-1:0]  out_low,
   output logic [SIDE_W-1:0] out_side
);
   // low holds unconsumed dividend bits on top, quotient bits below

   logic              valid_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  divisor_ff;
   logic [LOW_W-1:0]  low_ff, low_in;
   logic [SIDE_W-1:0] side_ff;
   logic [REM_W:0]    trial;
   logic              fits;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      trial  = {in_rem, in_low[LOW_W-1]};
      fits   = trial >= {1'b0, in_divisor};
      rem_in = fits ? REM_W'(trial - {1'b0, in_divisor}) : trial[REM_W-1:0];
      low_in = {in_low[LOW_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         rem_ff     <= rem_in;
         divisor_ff <= in_divisor;
         low_ff     <= low_in;
         side_ff    <= in_side;
      end
   end

   assign out_valid   = valid_ff;
   assign out_rem     = rem_ff;
   assign out_divisor = divisor_ff;
   assign out_low     = low_ff;
   assign out_side    = side_ff;

endmodule

// File: rtl/tao_lerp.sv
// ----------------------------------------------------------------------------
// tao_lerp
// Two stages: arctan table lookup, then the interpolation product plus round.
// ----------------------------------------------------------------------------
module tao_lerp #(
   parameter int INPUT_WIDTH   = 16,
   parameter int TABLE_ENTRIES = 32,
   localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [IDX_W-1:0]              in_index,
   input  logic [INPUT_WIDTH-1:0]        in_rem,
   input  logic [INPUT_WIDTH-1:0]        in_large,
   input  tao_pkg::tao_ctx_type          in_ctx,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [INPUT_WIDTH-1:0]        out_rem,
   output logic [tao_pkg::FRAC_W-1:0]    out_low,
   output logic [INPUT_WIDTH-1:0]        out_large,
   output logic [tao_pkg::ROM_W-1:0]     out_base,
   output tao_pkg::tao_ctx_type          out_ctx
);
   import tao_pkg::*;

   localparam int RW = $clog2(TABLE_ENTRIES + 1);
   localparam int DW = INPUT_WIDTH + FRAC_W;
   // table step as a ratio, 1/N
   localparam real INV_ENTRIES = 1.0 / real'(TABLE_ENTRIES);

   // entry i = arctan(i/N) in Q3.13, rounded to nearest
   function automatic logic [ROM_W-1:0] atan_entry(input int idx);
      real ang;
      ang = $atan(real'(idx) * INV_ENTRIES) * real'(1 << Q_FRAC);
      return ROM_W'($rtoi(ang + 0.5));
   endfunction

   logic [ROM_W-1:0] rom_table [TABLE_ENTRIES+1];

   for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_rom
      assign rom_table[g] = atan_entry(g);
   end

   // stage 1: lookup
   logic                   v1_ff;
   logic                   s1_ready;
   logic [ROM_W-1:0]       base_ff;
   logic [FRAC_W-1:0]      diff_ff;
   logic [INPUT_WIDTH-1:0] r_ff, large1_ff;
   tao_ctx_type            ctx1_ff;
   logic [RW-1:0]          idx_lo, idx_hi;

   // stage 2: rounded numerator of the fractional step
   logic                   v2_ff;
   logic                   s2_ready;
   logic [DW-1:0]          dividend_ff, dividend_in;
   logic [INPUT_WIDTH-1:0] large2_ff;
   logic [ROM_W-1:0]       base2_ff;
   tao_ctx_type            ctx2_ff;

   assign s2_ready = !v2_ff || out_ready;
   assign s1_ready = !v1_ff || s2_ready;
   assign in_ready = s1_ready;

   assign idx_lo = RW'(in_index);
   assign idx_hi = idx_lo + RW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (s1_ready) begin
         v1_ff <= in_valid;
      end
      if (s1_ready && in_valid) begin
         base_ff   <= rom_table[idx_lo];
         diff_ff   <= FRAC_W'(rom_table[idx_hi] - rom_table[idx_lo]);
         r_ff      <= in_rem;
         large1_ff <= in_large;
         ctx1_ff   <= in_ctx;
      end
   end

   // step*r + large/2 < (step+1)*large, so the quotient fits FRAC_W bits
   assign dividend_in = DW'(diff_ff) * DW'(r_ff) + DW'(large1_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (s2_ready) begin
         v2_ff <= v1_ff;
      end
      if (s2_ready && v1_ff) begin
         dividend_ff <= dividend_in;
         large2_ff   <= large1_ff;
         base2_ff    <= base_ff;
         ctx2_ff     <= ctx1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_rem   = dividend_ff[DW-1:FRAC_W];
   assign out_low   = dividend_ff[FRAC_W-1:0];
   assign out_large = large2_ff;
   assign out_base  = base2_ff;
   assign out_ctx   = ctx2_ff;

endmodule

// File: rtl/tao_unfold.sv
// ----------------------------------------------------------------------------
// tao_unfold
// Output register: first-octant angle mapped back to the full circle.
// ----------------------------------------------------------------------------
module tao_unfold (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [tao_pkg::FRAC_W-1:0]         in_quot,
   input  logic [tao_pkg::ROM_W-1:0]          in_base,
   input  tao_pkg::tao_ctx_type               in_ctx,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [tao_pkg::ANGLE_W-1:0] out_angle
);
   import tao_pkg::*;

   logic                      valid_ff;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic signed [ANGLE_W-1:0] oct;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (in_ctx.equal) begin
         oct = ANGLE_QUARTER_PI;
      end else if (in_ctx.fixed) begin
         oct = ANGLE_ZERO;
      end else begin
         oct = ANGLE_W'(in_base) + ANGLE_W'(in_quot);
      end
      angle_in = in_ctx.negate ? in_ctx.base - oct : in_ctx.base + oct;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_angle = angle_ff;

endmodule

// File: rtl/table_atan2_octant_top.sv
// ----------------------------------------------------------------------------
// table_atan2_octant_top
// Four-quadrant arctangent of (x, y) by table lookup and linear interpolation.
// Throughput: one request per cycle; each stage stalls only when full and blocked.
// Reset: synchronous, clears every stage valid bit; the arctan table is constant.
// ----------------------------------------------------------------------------
// Pipeline, one cell per register stage, each with its own valid bit:
//   fold (2)   magnitudes, sign flags, octant fold, small*N
//   index div  one cell per index bit: i = small*N / large, r = remainder
//   lerp (2)   table lookup at i and i+1, then step*r + large/2
//   frac div   one cell per bit of the interpolation step
//   unfold (1) octant value back to the full circle, output register
// A request moves forward whenever the next stage is empty or moving, so
// bubbles collapse and new requests are taken while a result waits.
module table_atan2_octant_top #(
   parameter int INPUT_WIDTH   = 16,
   parameter int TABLE_ENTRIES = 32
) (
   input  logic      clock,
   input  logic      reset,
   tao_req_if.sink   req_bus,
   tao_rsp_if.source rsp_bus
);
   import tao_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int FSIDE_W = ROM_W + CTX_W;

   // index divider chain: element 0 is the fold output, element IDX_W the lerp input
   logic                   idx_valid [IDX_W+1];
   logic                   idx_ready [IDX_W+1];
   logic [INPUT_WIDTH-1:0] idx_rem   [IDX_W+1];
   logic [INPUT_WIDTH-1:0] idx_div   [IDX_W+1];
   logic [IDX_W-1:0]       idx_low   [IDX_W+1];
   logic [CTX_W-1:0]       idx_side  [IDX_W+1];

   // fraction divider chain: side carries table base and context
   logic                   frac_valid [FRAC_W+1];
   logic                   frac_ready [FRAC_W+1];
   logic [INPUT_WIDTH-1:0] frac_rem   [FRAC_W+1];
   logic [INPUT_WIDTH-1:0] frac_div   [FRAC_W+1];
   logic [FRAC_W-1:0]      frac_low   [FRAC_W+1];
   logic [FSIDE_W-1:0]     frac_side  [FRAC_W+1];

   tao_ctx_type      fold_ctx;
   tao_ctx_type      lerp_ctx;
   tao_ctx_type      frac_ctx;
   logic [ROM_W-1:0] lerp_base;

   tao_fold #(
      .INPUT_WIDTH  (INPUT_WIDTH),
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_fold (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .in_x     (req_bus.x_coord),
      .in_y     (req_bus.y_coord),
      .out_valid(idx_valid[0]),
      .out_ready(idx_ready[0]),
      .out_rem  (idx_rem[0]),
      .out_low  (idx_low[0]),
      .out_large(idx_div[0]),
      .out_ctx  (fold_ctx)
   );

   assign idx_side[0] = fold_ctx;

   for (genvar k = 0; k < IDX_W; k++) begin : g_idx
      tao_div_cell #(
         .REM_W (INPUT_WIDTH),
         .LOW_W (IDX_W),
         .SIDE_W(CTX_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (idx_valid[k]),
         .in_ready   (idx_ready[k]),
         .in_rem     (idx_rem[k]),
         .in_divisor (idx_div[k]),
         .in_low     (idx_low[k]),
         .in_side    (idx_side[k]),
         .out_valid  (idx_valid[k+1]),
         .out_ready  (idx_ready[k+1]),
         .out_rem    (idx_rem[k+1]),
         .out_divisor(idx_div[k+1]),
         .out_low    (idx_low[k+1]),
         .out_side   (idx_side[k+1])
      );
   end

   assign lerp_ctx = tao_ctx_type'(idx_side[IDX_W]);

   // after the index cells: low = table index, rem = remainder r
   tao_lerp #(
      .INPUT_WIDTH  (INPUT_WIDTH),
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_lerp (
      .clock    (clock),
      .reset    (reset),
      .in_valid (idx_valid[IDX_W]),
      .in_ready (idx_ready[IDX_W]),
      .in_index (idx_low[IDX_W]),
      .in_rem   (idx_rem[IDX_W]),
      .in_large (idx_div[IDX_W]),
      .in_ctx   (lerp_ctx),
      .out_valid(frac_valid[0]),
      .out_ready(frac_ready[0]),
      .out_rem  (frac_rem[0]),
      .out_low  (frac_low[0]),
      .out_large(frac_div[0]),
      .out_base (lerp_base),
      .out_ctx  (frac_ctx)
   );

   assign frac_side[0] = {lerp_base, frac_ctx};

   for (genvar k = 0; k < FRAC_W; k++) begin : g_frac
      if (k < FRAC_W - 1) begin : g_mid
         tao_div_cell #(
            .REM_W (INPUT_WIDTH),
            .LOW_W (FRAC_W),
            .SIDE_W(FSIDE_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (frac_valid[k]),
            .in_ready   (frac_ready[k]),
            .in_rem     (frac_rem[k]),
            .in_divisor (frac_div[k]),
            .in_low     (frac_low[k]),
            .in_side    (frac_side[k]),
            .out_valid  (frac_valid[k+1]),
            .out_ready  (frac_ready[k+1]),
            .out_rem    (frac_rem[k+1]),
            .out_divisor(frac_div[k+1]),
            .out_low    (frac_low[k+1]),
            .out_side   (frac_side[k+1])
         );
      end else begin : g_last
         // final remainder and divisor are not needed past this cell
         tao_div_cell #(
            .REM_W (INPUT_WIDTH),
            .LOW_W (FRAC_W),
            .SIDE_W(FSIDE_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (frac_valid[k]),
            .in_ready   (frac_ready[k]),
            .in_rem     (frac_rem[k]),
            .in_divisor (frac_div[k]),
            .in_low     (frac_low[k]),
            .in_side    (frac_side[k]),
            .out_valid  (frac_valid[k+1]),
            .out_ready  (frac_ready[k+1]),
            .out_rem    (),
            .out_divisor(),
            .out_low    (frac_low[k+1]),
            .out_side   (frac_side[k+1])
         );
      end
   end

   // rounded interpolation step is the fraction quotient
   tao_unfold u_unfold (
      .clock    (clock),
      .reset    (reset),
      .in_valid (frac_valid[FRAC_W]),
      .in_ready (frac_ready[FRAC_W]),
      .in_quot  (frac_low[FRAC_W]),
      .in_base  (frac_side[FRAC_W][FSIDE_W-1:CTX_W]),
      .in_ctx   (tao_ctx_type'(frac_side[FRAC_W][CTX_W-1:0])),
      .out_valid(rsp_bus.valid),
      .out_ready(rsp_bus.ready),
      .out_angle(rsp_bus.angle)
   );

endmodule

// File: rtl/tao_checker.sv
// ----------------------------------------------------------------------------
// tao_checker
// Port-level checks on the arctangent pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module tao_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [tao_pkg::ANGLE_W-1:0] rsp_angle
);
   import tao_pkg::*;

   // nothing comes out right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a free output stage means every stage behind it can move
   a_ready_when_drained: assert property (@(posedge clock)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled with output free");

   // a blocked result holds its value
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle))
      else $error("stalled result changed");

   // results stay within minus pi to pi, checked only while shown
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(reset) |-> rsp_angle >= -ANGLE_PI && rsp_angle <= ANGLE_PI)
      else $error("angle out of range");

endmodule

bind table_atan2_octant_top tao_checker u_tao_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_angle(rsp_bus.angle)
);
